/* src/lc3x_pkg.sv */
package lc3x_pkg;

	// Command codes of the input channel.
	typedef enum logic [1:0] {
		CMD_EXEC  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_READ  = 2'd2,
		CMD_SETPC = 2'd3
	} cmd_t;

	// Status codes of the result channel.
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_BAD  = 2'd1;
	localparam logic [1:0] ST_TRAP = 2'd2;

	// Opcodes.
	localparam logic [3:0] OP_BR   = 4'd0;
	localparam logic [3:0] OP_ADD  = 4'd1;
	localparam logic [3:0] OP_LD   = 4'd2;
	localparam logic [3:0] OP_ST   = 4'd3;
	localparam logic [3:0] OP_JSR  = 4'd4;
	localparam logic [3:0] OP_AND  = 4'd5;
	localparam logic [3:0] OP_LDR  = 4'd6;
	localparam logic [3:0] OP_STR  = 4'd7;
	localparam logic [3:0] OP_RTI  = 4'd8;
	localparam logic [3:0] OP_NOT  = 4'd9;
	localparam logic [3:0] OP_LDI  = 4'd10;
	localparam logic [3:0] OP_STI  = 4'd11;
	localparam logic [3:0] OP_JMP  = 4'd12;
	localparam logic [3:0] OP_RSV  = 4'd13;
	localparam logic [3:0] OP_LEA  = 4'd14;
	localparam logic [3:0] OP_TRAP = 4'd15;

	localparam logic [2:0] FLAG_Z = 3'b010;

	// One queued transaction between the front and the back.
	typedef struct packed {
		cmd_t        cmd;
		logic [15:0] instruction;
		logic [15:0] address;
		logic [15:0] write_data;
	} item_t;

	// Result transaction.
	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  trap_vector;
		logic [15:0] program_counter;
		logic [15:0] result_word;
		logic [2:0]  flags;
	} result_t;

endpackage

/* src/lc3x_front.sv */
module lc3x_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  lc3x_pkg::item_t  in_item,
	output logic             q_valid,
	input  logic             q_ready,
	output lc3x_pkg::item_t  q_item
);

	// Two-entry queue that decouples acceptance from execution.
	lc3x_pkg::item_t mem_q [2];
	logic            wp_q, rp_q;
	logic [1:0]      cnt_q;
	logic            push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = mem_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	// Pointer and count update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_item;
	end

endmodule

/* src/lc3x_back.sv */
module lc3x_back #(
	parameter int MEM_WORDS = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_ready,
	input  lc3x_pkg::item_t   q_item,
	output logic              out_valid,
	input  logic              out_ready,
	output lc3x_pkg::result_t out_res
);

	localparam int AW = $clog2(MEM_WORDS);

	typedef enum logic [2:0] {
		S_IDLE, S_RD1, S_RD2, S_FIN
	} state_t;

	logic [15:0] mem [MEM_WORDS];
	logic [15:0] rf_q [8];
	logic [15:0] pc_q;
	logic [2:0]  flags_q;
	state_t      state_q;
	lc3x_pkg::item_t it_q;
	logic [15:0] pcn_q;
	logic [15:0] rdata_q;

	// Memory port, driven combinationally by the sequencer.
	logic        mwe;
	logic [15:0] maddr, mwdata;
	logic        mre;

	logic [3:0]  op;
	logic [2:0]  dr, sr1;
	logic [15:0] off9, off6, off11, imm5, opnd2, pcn, ea;

	assign op    = it_q.instruction[15:12];
	assign dr    = it_q.instruction[11:9];
	assign sr1   = it_q.instruction[8:6];
	assign off9  = {{7{it_q.instruction[8]}}, it_q.instruction[8:0]};
	assign off6  = {{10{it_q.instruction[5]}}, it_q.instruction[5:0]};
	assign off11 = {{5{it_q.instruction[10]}}, it_q.instruction[10:0]};
	assign imm5  = {{11{it_q.instruction[4]}}, it_q.instruction[4:0]};
	assign opnd2 = it_q.instruction[5] ? imm5 : rf_q[it_q.instruction[2:0]];
	assign pcn   = pcn_q;
	assign ea    = (op == lc3x_pkg::OP_LDR || op == lc3x_pkg::OP_STR)
		? rf_q[sr1] + off6 : pcn + off9;

	assign q_ready = (state_q == S_IDLE) && (!out_valid || out_ready);

	function automatic logic [2:0] nzp(input logic [15:0] v);
		if (v[15]) return 3'b100;
		else if (v == 16'd0) return 3'b010;
		else return 3'b001;
	endfunction

	// Memory access selection per state.
	always_comb begin
		mwe = 1'b0; mre = 1'b0; maddr = it_q.address; mwdata = it_q.write_data;
		if (state_q == S_RD1) begin
			if (it_q.cmd == lc3x_pkg::CMD_WRITE) mwe = 1'b1;
			else if (it_q.cmd == lc3x_pkg::CMD_READ) mre = 1'b1;
			else if (it_q.cmd == lc3x_pkg::CMD_EXEC) begin
				maddr  = ea;
				mwdata = rf_q[dr];
				if (op == lc3x_pkg::OP_ST || op == lc3x_pkg::OP_STR) mwe = 1'b1;
				if (op == lc3x_pkg::OP_LD || op == lc3x_pkg::OP_LDR ||
					op == lc3x_pkg::OP_LDI || op == lc3x_pkg::OP_STI) mre = 1'b1;
			end
		end else if (state_q == S_RD2) begin
			maddr  = rdata_q;
			mwdata = rf_q[dr];
			if (op == lc3x_pkg::OP_STI) mwe = 1'b1;
			else mre = 1'b1;
		end
	end

	// Word memory with registered read.
	always_ff @(posedge clk) begin
		if (mwe) mem[maddr[AW-1:0]] <= mwdata;
		if (mre) rdata_q <= mem[maddr[AW-1:0]];
	end

	// Sequencer: capture, memory steps, then retire with state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			pc_q      <= 16'd0;
			flags_q   <= lc3x_pkg::FLAG_Z;
			for (int i = 0; i < 8; i++) rf_q[i] <= 16'd0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_valid && q_ready) begin
						it_q    <= q_item;
						pcn_q   <= pc_q + 16'd1;
						state_q <= S_RD1;
					end
				end
				S_RD1: begin
					state_q <= ((it_q.cmd == lc3x_pkg::CMD_EXEC) &&
						(op == lc3x_pkg::OP_LDI || op == lc3x_pkg::OP_STI)) ? S_RD2 : S_FIN;
				end
				S_RD2: state_q <= S_FIN;
				S_FIN: begin
					logic [15:0] npc, res, wv;
					logic [2:0]  nfl;
					logic [1:0]  st;
					logic [7:0]  vec;
					logic        wr;
					npc = pc_q; res = 16'd0; nfl = flags_q; st = lc3x_pkg::ST_OK;
					vec = 8'd0; wr = 1'b0; wv = 16'd0;
					case (it_q.cmd)
						lc3x_pkg::CMD_READ:  res = rdata_q;
						lc3x_pkg::CMD_SETPC: npc = it_q.address;
						lc3x_pkg::CMD_EXEC: begin
							npc = pcn;
							case (op)
								lc3x_pkg::OP_BR:
									if ((it_q.instruction[11:9] & flags_q) != 3'd0) npc = pcn + off9;
								lc3x_pkg::OP_ADD: begin wr = 1'b1; wv = rf_q[sr1] + opnd2; end
								lc3x_pkg::OP_AND: begin wr = 1'b1; wv = rf_q[sr1] & opnd2; end
								lc3x_pkg::OP_NOT: begin wr = 1'b1; wv = ~rf_q[sr1]; end
								lc3x_pkg::OP_LEA: begin wr = 1'b1; wv = pcn + off9; end
								lc3x_pkg::OP_LD, lc3x_pkg::OP_LDR, lc3x_pkg::OP_LDI: begin
									wr = 1'b1; wv = rdata_q;
								end
								lc3x_pkg::OP_JMP: npc = rf_q[sr1];
								lc3x_pkg::OP_JSR: begin
									npc = it_q.instruction[11] ? pcn + off11 : rf_q[sr1];
									rf_q[7] <= pcn;
									res = pcn;
								end
								lc3x_pkg::OP_TRAP: begin
									st = lc3x_pkg::ST_TRAP; vec = it_q.instruction[7:0];
								end
								lc3x_pkg::OP_ST, lc3x_pkg::OP_STR, lc3x_pkg::OP_STI: ;
								default: st = lc3x_pkg::ST_BAD;
							endcase
							if (wr) begin
								rf_q[dr] <= wv;
								nfl = nzp(wv);
								res = wv;
							end
						end
						default: ;
					endcase
					pc_q    <= npc;
					flags_q <= nfl;
					out_res <= '{status: st, trap_vector: vec, program_counter: npc,
						result_word: res, flags: nfl};
					out_valid <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* src/lc3_instruction_execute.sv */
// Channel  | Handshake               | Payload
// in       | in_valid / in_ready     | cmd, instruction, address, write_data
// out      | out_valid / out_ready   | status, trap_vector, program_counter, result_word, flags
//
// Each transaction passes through the back sequencer's capture, memory access and retire
// states; LDI and STI add a second state for the dependent memory access.
// With the single memory port and in-order state update, one transaction retires before the next is taken.
// Reset clears registers, PC and queue; flags reset to Z. Memory is not cleared.
// A two-entry queue keeps accepting input, until full, while a result waits on out_ready.
module lc3_instruction_execute #(
	parameter int MEM_WORDS = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [15:0] instruction,
	input  logic [15:0] address,
	input  logic [15:0] write_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [7:0]  trap_vector,
	output logic [15:0] program_counter,
	output logic [15:0] result_word,
	output logic [2:0]  flags
);

	lc3x_pkg::item_t   in_item, q_item;
	lc3x_pkg::result_t res;
	logic              q_valid, q_ready;

	assign in_item = '{cmd: lc3x_pkg::cmd_t'(cmd), instruction: instruction,
		address: address, write_data: write_data};

	// Front queue.
	lc3x_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);

	// Back execution sequencer.
	lc3x_back #(.MEM_WORDS(MEM_WORDS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready),
		.q_item(q_item), .out_valid(out_valid), .out_ready(out_ready), .out_res(res)
	);

	assign status          = res.status;
	assign trap_vector     = res.trap_vector;
	assign program_counter = res.program_counter;
	assign result_word     = res.result_word;
	assign flags           = res.flags;

endmodule

/* src/lc3x_checker.sv */
module lc3x_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [7:0]  trap_vector,
	input logic [2:0]  flags
);

	// A stalled result transaction holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result changed while stalled");

	// Flags always carry exactly one condition.
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot(flags))
		else $error("flags not one-hot");

	// The trap vector is zero unless a trap is reported.
	a_vec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != lc3x_pkg::ST_TRAP |-> trap_vector == 8'd0)
		else $error("stray trap vector");

	// Status never shows the unused code.
	a_st: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= lc3x_pkg::ST_TRAP)
		else $error("bad status code");

endmodule

bind lc3_instruction_execute lc3x_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.status(status), .trap_vector(trap_vector), .flags(flags)
);
